[hw/rtl/bm25ds_pkg.sv]
// ----------------------------------------------------------------------------
// bm25ds_pkg: shared constants and types of the BM25 document scorer
// Fixed point widths, register reset values, register indexes and the
// pipeline latencies that the lanes and the top level agree on.
// ----------------------------------------------------------------------------
package bm25ds_pkg;

    // Query terms
    localparam int MAX_TERMS    = 4;
    localparam int NUM_TERMS_DEF = 4;

    // Field widths
    localparam int DL_W    = 20;
    localparam int TF_W    = 16;
    localparam int K1_W    = 16;
    localparam int B_W     = 17;
    localparam int AVG_W   = 32;
    localparam int IDF_W   = 24;
    localparam int SCORE_W = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Fixed point ones
    localparam logic [B_W-1:0]  ONE_Q16 = B_W'(65536);
    localparam logic [B_W-1:0]  ONE_Q12 = B_W'(4096);

    // Register reset values
    localparam logic [K1_W-1:0]  K1_RST  = K1_W'(4915);
    localparam logic [B_W-1:0]   B_RST   = B_W'(49152);
    localparam logic [AVG_W-1:0] AVG_RST = '0;
    localparam logic [IDF_W-1:0] IDF_RST = '0;

    // Internal widths
    localparam int RATIO_W = DL_W + 24;          // length ratio, Q.16
    localparam int NORM_W  = 45;                 // normalized length, Q.16
    localparam int LNORM_W = 49;                 // k1 scaled norm, Q.16
    localparam int DEN_W   = 50;                 // term divisor
    localparam int NUM_W   = 61;                 // term dividend
    localparam int TERM_W  = 45;                 // term quotient
    localparam int SUM_W   = TERM_W + 2;

    // Latencies in pipeline stages
    localparam int NORM_LAT = RATIO_W + 4;
    localparam int LANE_LAT = NORM_LAT + TERM_W;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_K1   = 3'd0,
        CFG_B    = 3'd1,
        CFG_AVG  = 3'd2,
        CFG_IDF0 = 3'd3,
        CFG_IDF1 = 3'd4,
        CFG_IDF2 = 3'd5,
        CFG_IDF3 = 3'd6
    } t_cfg_idx;

endpackage

[hw/rtl/bm25ds_in_if.sv]
// ----------------------------------------------------------------------------
// bm25ds_in_if: document word channel
// Valid/ready channel carrying the document length and term frequencies.
// ----------------------------------------------------------------------------
interface bm25ds_in_if;
    logic                          valid;
    logic                          ready;
    logic [bm25ds_pkg::DL_W-1:0]   doc_len;
    logic [bm25ds_pkg::TF_W-1:0]   tf_term0;
    logic [bm25ds_pkg::TF_W-1:0]   tf_term1;
    logic [bm25ds_pkg::TF_W-1:0]   tf_term2;
    logic [bm25ds_pkg::TF_W-1:0]   tf_term3;

    modport source (
        output valid, doc_len, tf_term0, tf_term1, tf_term2, tf_term3,
        input  ready
    );
    modport sink (
        input  valid, doc_len, tf_term0, tf_term1, tf_term2, tf_term3,
        output ready
    );
endinterface

[hw/rtl/bm25ds_out_if.sv]
// ----------------------------------------------------------------------------
// bm25ds_out_if: score word channel
// Valid/ready channel carrying the summed score and its clip flag.
// ----------------------------------------------------------------------------
interface bm25ds_out_if;
    logic                           valid;
    logic                           ready;
    logic [bm25ds_pkg::SCORE_W-1:0] score;
    logic                           saturated;

    modport source (
        output valid, score, saturated,
        input  ready
    );
    modport sink (
        input  valid, score, saturated,
        output ready
    );
endinterface

[hw/rtl/bm25ds_div.sv]
// ----------------------------------------------------------------------------
// bm25ds_div: pipelined restoring divider
// One quotient bit per stage, QW stages. The caller supplies the starting
// partial remainder, which must be below the divisor.
// ----------------------------------------------------------------------------
module bm25ds_div #(
    parameter int QW = 44,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem0,
    input  logic [QW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_num [QW];
    logic [DW-1:0] r_den [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [DW-1:0] w_rem;
        logic [QW-1:0] w_num;
        logic [DW-1:0] w_den;
        logic [DW:0]   w_try;
        logic          w_ge;
        logic [DW-1:0] n_rem;

        // Pick the previous stage, or the inputs at the head
        if (i == 0) begin : g_head
            assign w_rem = i_rem0;
            assign w_num = i_num;
            assign w_den = i_den;
        end else begin : g_body
            assign w_rem = r_rem[i-1];
            assign w_num = r_num[i-1];
            assign w_den = r_den[i-1];
        end

        // Bring down one dividend bit and subtract where it fits
        always_comb begin
            w_try = {w_rem, w_num[QW-1]};
            w_ge  = (w_try >= {1'b0, w_den});
            n_rem = w_ge ? DW'(w_try - {1'b0, w_den}) : w_try[DW-1:0];
        end

        // Advance one stage; quotient bits shift in from the bottom
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= n_rem;
                r_num[i] <= {w_num[QW-2:0], w_ge};
                r_den[i] <= w_den;
            end
        end
    end

    assign o_quo = r_num[QW-1];

endmodule

[hw/rtl/bm25ds_norm.sv]
// ----------------------------------------------------------------------------
// bm25ds_norm: document length normalization
// Divides the document length by the average length, then forms
// k1 * (1 - b + b * ratio), shared by all term lanes.
// ----------------------------------------------------------------------------
module bm25ds_norm (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [bm25ds_pkg::DL_W-1:0]      i_doc_len,
    input  logic [bm25ds_pkg::AVG_W-1:0]     i_avg,
    input  logic [bm25ds_pkg::B_W-1:0]       i_bb,
    input  logic [bm25ds_pkg::K1_W-1:0]      i_k1,
    output logic [bm25ds_pkg::LNORM_W-1:0]   o_lnorm
);

    localparam int RW   = bm25ds_pkg::RATIO_W;
    localparam int RH   = RW / 2;
    localparam int NW   = bm25ds_pkg::NORM_W;
    localparam int NH   = (NW + 1) / 2;
    localparam int PW   = bm25ds_pkg::B_W + RW - RH;
    localparam int LW   = bm25ds_pkg::K1_W + NH;
    localparam int SW   = 61;

    logic [RW-1:0]  w_quo;
    logic [RW-1:0]  w_ratio;
    logic [PW-1:0]  r_p_lo;
    logic [PW-1:0]  r_p_hi;
    logic [NW-1:0]  r_norm;
    logic [LW-1:0]  r_l_lo;
    logic [LW-1:0]  r_l_hi;
    logic [SW-1:0]  w_bsum;
    logic [SW-1:0]  w_lsum;

    // Length ratio in Q.16
    bm25ds_div #(
        .QW (RW),
        .DW (bm25ds_pkg::AVG_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rem0 ('0),
        .i_num  ({i_doc_len, 24'd0}),
        .i_den  (i_avg),
        .o_quo  (w_quo)
    );

    // Zero average length disables the ratio
    assign w_ratio = (i_avg == '0) ? '0 : w_quo;

    // b * ratio as two partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_lo <= PW'(i_bb) * PW'(w_ratio[RH-1:0]);
            r_p_hi <= PW'(i_bb) * PW'(w_ratio[RW-1:RH]);
        end
    end

    // Combine and add 1 - b
    assign w_bsum = SW'(r_p_lo) + SW'({r_p_hi, {RH{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_norm <= NW'(bm25ds_pkg::ONE_Q16 - i_bb) + w_bsum[SW-1:16];
        end
    end

    // k1 * norm as two partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l_lo <= LW'(i_k1) * LW'(r_norm[NH-1:0]);
            r_l_hi <= LW'(i_k1) * LW'(r_norm[NW-1:NH]);
        end
    end

    // Combine and drop the Q4.12 fraction
    assign w_lsum = SW'(r_l_lo) + SW'({r_l_hi, {NH{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lnorm <= w_lsum[SW-1:12];
        end
    end

endmodule

[hw/rtl/bm25ds_lane.sv]
// ----------------------------------------------------------------------------
// bm25ds_lane: one query term of the BM25 score
// Builds idf * tf * (k1 + 1) while the shared norm is formed, then divides
// it by tf + k1 * norm in a pipelined divider.
// ----------------------------------------------------------------------------
module bm25ds_lane (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [bm25ds_pkg::TF_W-1:0]      i_tf,
    input  logic [bm25ds_pkg::IDF_W-1:0]     i_idf,
    input  logic [bm25ds_pkg::B_W-1:0]       i_k1p1,
    input  logic [bm25ds_pkg::LNORM_W-1:0]   i_lnorm,
    output logic [bm25ds_pkg::TERM_W-1:0]    o_term
);

    localparam int TW  = bm25ds_pkg::TF_W;
    localparam int AW  = bm25ds_pkg::IDF_W + TW;
    localparam int AH  = AW / 2;
    localparam int BW  = AH + bm25ds_pkg::B_W;
    localparam int CW  = AW + bm25ds_pkg::B_W;
    localparam int NW  = bm25ds_pkg::NUM_W;
    localparam int QW  = bm25ds_pkg::TERM_W;
    localparam int DW  = bm25ds_pkg::DEN_W;
    localparam int DLY = bm25ds_pkg::NORM_LAT - 3;

    logic [AW-1:0] r_a_prod;
    logic [TW-1:0] r_a_tf;
    logic [BW-1:0] r_b_lo;
    logic [BW-1:0] r_b_hi;
    logic [TW-1:0] r_b_tf;
    logic [NW-1:0] r_c_num;
    logic [TW-1:0] r_c_tf;
    logic [CW-1:0] w_csum;
    logic [NW-1:0] r_d_num [DLY];
    logic [TW-1:0] r_d_tf  [DLY];
    logic          r_zero  [QW];
    logic [DW-1:0] w_den;
    logic [QW-1:0] w_quo;

    // idf * tf
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_prod <= AW'(i_idf) * AW'(i_tf);
            r_a_tf   <= i_tf;
        end
    end

    // times (k1 + 1) in two halves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_lo <= BW'(r_a_prod[AH-1:0]) * BW'(i_k1p1);
            r_b_hi <= BW'(r_a_prod[AW-1:AH]) * BW'(i_k1p1);
            r_b_tf <= r_a_tf;
        end
    end

    // Combine halves and scale to Q.16 of the quotient
    assign w_csum = CW'(r_b_lo) + CW'({r_b_hi, {AH{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_num <= {w_csum, 4'd0};
            r_c_tf  <= r_b_tf;
        end
    end

    // Hold numerator and frequency until the shared norm arrives
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_num[0] <= r_c_num;
            r_d_tf[0]  <= r_c_tf;
            for (int i = 1; i < DLY; i++) begin
                r_d_num[i] <= r_d_num[i-1];
                r_d_tf[i]  <= r_d_tf[i-1];
            end
        end
    end

    // Divisor: tf in Q.16 plus the scaled norm
    assign w_den = DW'({r_d_tf[DLY-1], 16'd0}) + DW'(i_lnorm);

    // The quotient fits TERM_W bits since the divisor of a present term is at least one in Q.16
    bm25ds_div #(
        .QW (QW),
        .DW (DW)
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rem0 (DW'(r_d_num[DLY-1][NW-1:QW])),
        .i_num  (r_d_num[DLY-1][QW-1:0]),
        .i_den  (w_den),
        .o_quo  (w_quo)
    );

    // Track absent terms alongside the divider
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (r_d_tf[DLY-1] == '0);
            for (int i = 1; i < QW; i++) begin
                r_zero[i] <= r_zero[i-1];
            end
        end
    end

    // Drop the quotient of an absent term
    assign o_term = r_zero[QW-1] ? '0 : w_quo;

endmodule

[hw/rtl/bm25_document_score_top.sv]
// ----------------------------------------------------------------------------
// bm25_document_score_top: Okapi BM25 scorer for one document per word
// Shared length normalization, one divider lane per query term and a
// merging stage that sums the terms and clips the score.
// ----------------------------------------------------------------------------
// Usage:
//   i_doc carries a document word (length and term frequencies) under
//   valid/ready; o_res returns one word per document with the Q16.16 score
//   and a flag when the sum was clipped to all ones. Results leave in the
//   order documents arrive.
//   Registers (k1, b, average length, IDF weights) are written through
//   i_cfg_wen / i_cfg_idx / i_cfg_data while no document is in flight;
//   the user must keep to this, as the block does not enforce it.
//   Throughput is one document per cycle: the length divider and each term
//   divider are pipelined at one quotient bit per stage, 44 and 45 stages.
//   When o_res stalls, the pipeline keeps moving as long as its last stage
//   is empty, so documents are still taken while a result waits; once a
//   finished score sits behind the held word, i_doc.ready drops.
//   Reset empties the pipeline and the output, and returns registers to
//   k1 = 1.2, b = 0.75, zero average length and zero IDF weights.
// ----------------------------------------------------------------------------
module bm25_document_score_top #(
    parameter int NUM_TERMS = bm25ds_pkg::NUM_TERMS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bm25ds_in_if.sink                           i_doc,
    bm25ds_out_if.source                        o_res,
    input  logic                                i_cfg_wen,
    input  logic [bm25ds_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bm25ds_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int MT  = bm25ds_pkg::MAX_TERMS;
    localparam int LAT = bm25ds_pkg::LANE_LAT;
    localparam int QW  = bm25ds_pkg::TERM_W;
    localparam int SW  = bm25ds_pkg::SUM_W;
    localparam int OW  = bm25ds_pkg::SCORE_W;

    logic [bm25ds_pkg::K1_W-1:0]    r_k1;
    logic [bm25ds_pkg::B_W-1:0]     r_b;
    logic [bm25ds_pkg::AVG_W-1:0]   r_avg;
    logic [bm25ds_pkg::IDF_W-1:0]   r_idf [MT];

    logic [bm25ds_pkg::B_W-1:0]     w_bb;
    logic [bm25ds_pkg::B_W-1:0]     w_k1p1;
    logic [bm25ds_pkg::LNORM_W-1:0] w_lnorm;
    logic [bm25ds_pkg::TF_W-1:0]    w_tf   [MT];
    logic [QW-1:0]                  w_term [MT];
    logic [SW-1:0]                  w_sum;

    logic                           w_adv;
    logic [LAT-1:0]                 r_vld;
    logic                           r_out_valid;
    logic [OW-1:0]                  r_score;
    logic                           r_sat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1  <= bm25ds_pkg::K1_RST;
            r_b   <= bm25ds_pkg::B_RST;
            r_avg <= bm25ds_pkg::AVG_RST;
            for (int t = 0; t < MT; t++) begin
                r_idf[t] <= bm25ds_pkg::IDF_RST;
            end
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                bm25ds_pkg::CFG_K1:   r_k1     <= i_cfg_data[bm25ds_pkg::K1_W-1:0];
                bm25ds_pkg::CFG_B:    r_b      <= i_cfg_data[bm25ds_pkg::B_W-1:0];
                bm25ds_pkg::CFG_AVG:  r_avg    <= i_cfg_data[bm25ds_pkg::AVG_W-1:0];
                bm25ds_pkg::CFG_IDF0: r_idf[0] <= i_cfg_data[bm25ds_pkg::IDF_W-1:0];
                bm25ds_pkg::CFG_IDF1: r_idf[1] <= i_cfg_data[bm25ds_pkg::IDF_W-1:0];
                bm25ds_pkg::CFG_IDF2: r_idf[2] <= i_cfg_data[bm25ds_pkg::IDF_W-1:0];
                bm25ds_pkg::CFG_IDF3: r_idf[3] <= i_cfg_data[bm25ds_pkg::IDF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp b to one, form k1 + 1
    assign w_bb   = (r_b > bm25ds_pkg::ONE_Q16) ? bm25ds_pkg::ONE_Q16 : r_b;
    assign w_k1p1 = bm25ds_pkg::B_W'(r_k1) + bm25ds_pkg::ONE_Q12;

    // Advance unless a finished word is blocked behind a held output
    assign w_adv       = !r_vld[LAT-1] || !r_out_valid || o_res.ready;
    assign i_doc.ready = w_adv;

    // Word valid line across the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_doc.valid};
        end
    end

    // Shared length normalization
    bm25ds_norm u_norm (
        .i_clk        (i_clk),
        .i_en         (w_adv),
        .i_doc_len    (i_doc.doc_len),
        .i_avg        (r_avg),
        .i_bb         (w_bb),
        .i_k1         (r_k1),
        .o_lnorm      (w_lnorm)
    );

    assign w_tf[0] = i_doc.tf_term0;
    assign w_tf[1] = i_doc.tf_term1;
    assign w_tf[2] = i_doc.tf_term2;
    assign w_tf[3] = i_doc.tf_term3;

    // One lane per active query term
    for (genvar t = 0; t < MT; t++) begin : g_lane
        if (t < NUM_TERMS) begin : g_on
            bm25ds_lane u_lane (
                .i_clk   (i_clk),
                .i_en    (w_adv),
                .i_tf    (w_tf[t]),
                .i_idf   (r_idf[t]),
                .i_k1p1  (w_k1p1),
                .i_lnorm (w_lnorm),
                .o_term  (w_term[t])
            );
        end else begin : g_off
            assign w_term[t] = '0;
        end
    end

    // Merge lane results
    assign w_sum = SW'(w_term[0]) + SW'(w_term[1]) + SW'(w_term[2]) + SW'(w_term[3]);

    // Output word: clip and hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_vld[LAT-1]) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_vld[LAT-1]) begin
            r_sat   <= (w_sum[SW-1:OW] != '0);
            r_score <= (w_sum[SW-1:OW] != '0) ? {OW{1'b1}} : w_sum[OW-1:0];
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.score     = r_score;
    assign o_res.saturated = r_sat;

`ifndef SYNTHESIS
    // A clipped score reads all ones
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_sat) |-> (r_score == {OW{1'b1}}))
        else $error("clipped score is not all ones");

    // A finished word behind a held output blocks the input
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-1] && r_out_valid && !o_res.ready) |-> !i_doc.ready)
        else $error("input taken while pipeline end is blocked");

    // An accepted word enters the valid line
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_doc.valid && i_doc.ready) |=> r_vld[0])
        else $error("accepted word lost at pipeline head");

    // A held output word is not lost while the pipeline stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> r_out_valid)
        else $error("output word dropped without handshake");
`endif

endmodule
